[hw/rtl/pid_arx_pkg.sv]
// Shared types, constants and arithmetic helpers for the PID/ARX closed-loop step block.
package pid_arx_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int RND_W     = PROD_W - FRAC_BITS;
   localparam int ACC_W     = RND_W + 2;
   localparam int CSR_IDX_W = 4;
   localparam int MODE_W    = 2;
   localparam int DSUM_W    = 6;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [RND_W-1:0]  rnd_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   localparam longint SIN60_Q30 = 64'sd929887697;
   localparam word_type Q_ONE = WORD_W'(64'sd1 <<< FRAC_BITS);
   localparam word_type Q_SIN60 =
      WORD_W'((SIN60_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
   localparam logic [WORD_W-1:0] STEP_START = WORD_W'(5);

   localparam acc_type SAT_MAX = ACC_W'(32'sh7fffffff);
   localparam acc_type SAT_MIN = ACC_W'(32'sh80000000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P     = 4'd0,
      REG_GAIN_I     = 4'd1,
      REG_GAIN_D     = 4'd2,
      REG_TARGET     = 4'd3,
      REG_WAVE_MODE  = 4'd4,
      REG_FB_COEF1   = 4'd5,
      REG_FWD_COEF0  = 4'd6,
      REG_FWD_COEF1  = 4'd7
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      WAVE_STEP   = 2'd0,
      WAVE_SINE   = 2'd1,
      WAVE_SQUARE = 2'd2
   } wave_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_Y0, ST_Y1, ST_Y2, ST_YSAT, ST_ERR,
      ST_INT, ST_P1, ST_P2, ST_CSAT, ST_DRIVE
   } state_type;

   typedef enum logic [2:0] {
      MS_B0, MS_B1, MS_A1, MS_KP, MS_KI, MS_KD
   } mul_sel_type;

   typedef enum logic [1:0] {
      AC_HOLD, AC_LOAD, AC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_req;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        y_sat;
      logic        err_calc;
      logic        int_upd;
      logic        ctrl_sat;
      logic        commit;
   } cmd_type;

   // Round to nearest with ties toward plus infinity, then drop the fraction.
   function automatic rnd_type round_prod(input prod_type p);
      prod_type t;
      t = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
      return t[PROD_W-1:FRAC_BITS];
   endfunction

   function automatic word_type sat_word(input acc_type v);
      word_type r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[WORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

   // Base-4 digit sum; since 4 is 1 mod 3 it keeps the value mod 3.
   function automatic logic [DSUM_W-1:0] digit_sum(input logic [WORD_W-1:0] x);
      logic [DSUM_W-1:0] s;
      s = '0;
      for (int i = 0; i < WORD_W / 2; i++) begin
         s = s + DSUM_W'(x[2*i +: 2]);
      end
      return s;
   endfunction

   function automatic logic [1:0] mod3_small(input logic [DSUM_W-1:0] s);
      logic [3:0] t;
      logic [2:0] u;
      logic [1:0] r;
      t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
      u = 3'(t[1:0]) + 3'(t[3:2]);
      r = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
      return r;
   endfunction

   // Index mod 6 follows from the index mod 3 and its lowest bit.
   function automatic word_type wave_value(input logic [WORD_W-1:0] idx,
                                           input logic [1:0] r3,
                                           input logic [MODE_W-1:0] mode);
      word_type w;
      unique case (mode)
         WAVE_SINE: begin
            if (r3 == 2'd0) begin
               w = '0;
            end else if ((r3 == 2'd1 && idx[0]) || (r3 == 2'd2 && !idx[0])) begin
               w = Q_SIN60;
            end else begin
               w = -Q_SIN60;
            end
         end
         WAVE_SQUARE: w = (r3 < 2'd2) ? Q_ONE : '0;
         default:     w = (idx >= STEP_START) ? Q_ONE : '0;
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/pid_arx_ctrl.sv]
// Sequencing state machine for the PID/ARX step: orders the shared multiplier and commits.
module pid_arx_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pid_arx_pkg::cmd_type cmd
);

   pid_arx_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pid_arx_pkg::ST_IDLE:  if (req_valid) state_in = pid_arx_pkg::ST_Y0;
         pid_arx_pkg::ST_Y0:    state_in = pid_arx_pkg::ST_Y1;
         pid_arx_pkg::ST_Y1:    state_in = pid_arx_pkg::ST_Y2;
         pid_arx_pkg::ST_Y2:    state_in = pid_arx_pkg::ST_YSAT;
         pid_arx_pkg::ST_YSAT:  state_in = pid_arx_pkg::ST_ERR;
         pid_arx_pkg::ST_ERR:   state_in = pid_arx_pkg::ST_INT;
         pid_arx_pkg::ST_INT:   state_in = pid_arx_pkg::ST_P1;
         pid_arx_pkg::ST_P1:    state_in = pid_arx_pkg::ST_P2;
         pid_arx_pkg::ST_P2:    state_in = pid_arx_pkg::ST_CSAT;
         pid_arx_pkg::ST_CSAT:  state_in = pid_arx_pkg::ST_DRIVE;
         pid_arx_pkg::ST_DRIVE: if (!rsp_valid_ff || rsp_ready) state_in = pid_arx_pkg::ST_IDLE;
         default:               state_in = pid_arx_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = pid_arx_pkg::MS_B0;
      cmd.acc_op  = pid_arx_pkg::AC_HOLD;
      req_ready   = 1'b0;
      unique case (state_ff)
         pid_arx_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         pid_arx_pkg::ST_Y0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pid_arx_pkg::MS_B0;
         end
         pid_arx_pkg::ST_Y1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pid_arx_pkg::MS_B1;
            cmd.acc_op  = pid_arx_pkg::AC_LOAD;
         end
         pid_arx_pkg::ST_Y2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pid_arx_pkg::MS_A1;
            cmd.acc_op  = pid_arx_pkg::AC_ADD;
         end
         pid_arx_pkg::ST_YSAT: cmd.y_sat = 1'b1;
         pid_arx_pkg::ST_ERR:  cmd.err_calc = 1'b1;
         pid_arx_pkg::ST_INT: begin
            cmd.int_upd = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pid_arx_pkg::MS_KP;
         end
         pid_arx_pkg::ST_P1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pid_arx_pkg::MS_KI;
            cmd.acc_op  = pid_arx_pkg::AC_LOAD;
         end
         pid_arx_pkg::ST_P2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pid_arx_pkg::MS_KD;
            cmd.acc_op  = pid_arx_pkg::AC_ADD;
         end
         pid_arx_pkg::ST_CSAT:  cmd.ctrl_sat = 1'b1;
         pid_arx_pkg::ST_DRIVE: cmd.commit = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // The output register holds one finished request until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pid_arx_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over one not yet taken");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == pid_arx_pkg::ST_Y0)
      else $error("accepted request did not start the sequence");

   a_drive_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pid_arx_pkg::ST_DRIVE && !cmd.commit) |=>
         state_ff == pid_arx_pkg::ST_DRIVE)
      else $error("left final state without committing");

endmodule

[hw/rtl/pid_arx_dp.sv]
// Datapath for the PID/ARX step: registers, shared multiplier, accumulator and loop state.
module pid_arx_dp (
   input  logic                                       clock,
   input  logic                                       reset,
   input  pid_arx_pkg::cmd_type                       cmd,
   input  logic [pid_arx_pkg::WORD_W-1:0]             req_step_index,
   input  logic                                       csr_write,
   input  logic [pid_arx_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pid_arx_pkg::WORD_W-1:0]             csr_data,
   output logic signed [pid_arx_pkg::WORD_W-1:0]      rsp_plant_output,
   output logic signed [pid_arx_pkg::WORD_W-1:0]      rsp_control_value,
   output logic signed [pid_arx_pkg::WORD_W-1:0]      rsp_model_drive,
   output logic signed [pid_arx_pkg::WORD_W-1:0]      rsp_wave_value
);

   pid_arx_pkg::word_type gain_p_ff, gain_i_ff, gain_d_ff, target_ff;
   pid_arx_pkg::word_type fb_coef1_ff, fwd_coef0_ff, fwd_coef1_ff;
   logic [pid_arx_pkg::MODE_W-1:0] wave_mode_ff;

   logic [pid_arx_pkg::WORD_W-1:0] index_ff;
   logic [pid_arx_pkg::DSUM_W-1:0] dsum_ff;
   pid_arx_pkg::word_type wave_ff;

   pid_arx_pkg::word_type mul_a, mul_b;
   pid_arx_pkg::prod_type prod_ff;
   pid_arx_pkg::acc_type  acc_ff, prod_ext;

   pid_arx_pkg::word_type y_ff, e_ff, de_ff, ctrl_ff, drive_in;
   pid_arx_pkg::word_type error_sum_ff, last_error_ff, drive0_ff, drive1_ff, out_hist_ff;

   pid_arx_pkg::word_type out_y_ff, out_ctrl_ff, out_drive_ff, out_wave_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 32'sd65536;
         gain_i_ff    <= 32'sd6554;
         gain_d_ff    <= 32'sd3277;
         target_ff    <= '0;
         wave_mode_ff <= pid_arx_pkg::WAVE_SQUARE;
         fb_coef1_ff  <= 32'sd32768;
         fwd_coef0_ff <= 32'sd39322;
         fwd_coef1_ff <= 32'sd45875;
      end else if (csr_write) begin
         unique case (csr_index)
            pid_arx_pkg::REG_GAIN_P:    gain_p_ff    <= csr_data;
            pid_arx_pkg::REG_GAIN_I:    gain_i_ff    <= csr_data;
            pid_arx_pkg::REG_GAIN_D:    gain_d_ff    <= csr_data;
            pid_arx_pkg::REG_TARGET:    target_ff    <= csr_data;
            pid_arx_pkg::REG_WAVE_MODE: wave_mode_ff <= csr_data[pid_arx_pkg::MODE_W-1:0];
            pid_arx_pkg::REG_FB_COEF1:  fb_coef1_ff  <= csr_data;
            pid_arx_pkg::REG_FWD_COEF0: fwd_coef0_ff <= csr_data;
            pid_arx_pkg::REG_FWD_COEF1: fwd_coef1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The index stays put for the whole sequence, so the generator settles in two stages.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         index_ff <= req_step_index;
      end
      dsum_ff <= pid_arx_pkg::digit_sum(index_ff);
      wave_ff <= pid_arx_pkg::wave_value(index_ff, pid_arx_pkg::mod3_small(dsum_ff),
                                         wave_mode_ff);
   end

   always_comb begin
      unique case (cmd.mul_sel)
         pid_arx_pkg::MS_B0: begin mul_a = fwd_coef0_ff; mul_b = drive0_ff;    end
         pid_arx_pkg::MS_B1: begin mul_a = fwd_coef1_ff; mul_b = drive1_ff;    end
         pid_arx_pkg::MS_A1: begin mul_a = fb_coef1_ff;  mul_b = out_hist_ff;  end
         pid_arx_pkg::MS_KP: begin mul_a = gain_p_ff;    mul_b = e_ff;         end
         pid_arx_pkg::MS_KI: begin mul_a = gain_i_ff;    mul_b = error_sum_ff; end
         pid_arx_pkg::MS_KD: begin mul_a = gain_d_ff;    mul_b = de_ff;        end
         default:            begin mul_a = gain_p_ff;    mul_b = e_ff;         end
      endcase
   end

   assign prod_ext = pid_arx_pkg::ACC_W'(pid_arx_pkg::round_prod(prod_ff));
   assign drive_in = pid_arx_pkg::sat_word(pid_arx_pkg::ACC_W'(wave_ff)
                                           + pid_arx_pkg::ACC_W'(ctrl_ff));

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= pid_arx_pkg::PROD_W'(mul_a) * pid_arx_pkg::PROD_W'(mul_b);
      end
      unique case (cmd.acc_op)
         pid_arx_pkg::AC_LOAD: acc_ff <= prod_ext;
         pid_arx_pkg::AC_ADD:  acc_ff <= acc_ff + prod_ext;
         default: ;
      endcase
      // The feedback term enters with a minus sign.
      if (cmd.y_sat) begin
         y_ff <= pid_arx_pkg::sat_word(acc_ff - prod_ext);
      end
      if (cmd.err_calc) begin
         e_ff <= pid_arx_pkg::sat_word(pid_arx_pkg::ACC_W'(target_ff)
                                       - pid_arx_pkg::ACC_W'(y_ff));
      end
      if (cmd.int_upd) begin
         de_ff <= pid_arx_pkg::sat_word(pid_arx_pkg::ACC_W'(e_ff)
                                        - pid_arx_pkg::ACC_W'(last_error_ff));
      end
      if (cmd.ctrl_sat) begin
         ctrl_ff <= pid_arx_pkg::sat_word(acc_ff + prod_ext);
      end
      if (cmd.commit) begin
         out_y_ff     <= y_ff;
         out_ctrl_ff  <= ctrl_ff;
         out_drive_ff <= drive_in;
         out_wave_ff  <= wave_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         drive0_ff     <= '0;
         drive1_ff     <= '0;
         out_hist_ff   <= '0;
      end else begin
         if (cmd.int_upd) begin
            error_sum_ff <= pid_arx_pkg::sat_word(pid_arx_pkg::ACC_W'(error_sum_ff)
                                                  + pid_arx_pkg::ACC_W'(e_ff));
         end
         if (cmd.commit) begin
            last_error_ff <= e_ff;
            drive1_ff     <= drive0_ff;
            drive0_ff     <= drive_in;
            out_hist_ff   <= y_ff;
         end
      end
   end

   assign rsp_plant_output  = out_y_ff;
   assign rsp_control_value = out_ctrl_ff;
   assign rsp_model_drive   = out_drive_ff;
   assign rsp_wave_value    = out_wave_ff;

endmodule

[hw/rtl/pid_arx_closed_loop_step.sv]
// Top level of the closed-loop PID controller driving an ARX plant model, one tick per request.
//
// A request on req_ carries a time index. From it the block makes a test signal, evaluates
// the ARX model from its input and output history, runs the PID on the setpoint error and
// pushes test signal plus control into the history. The response on rsp_ carries the
// model output, the control value, the new model input and the test signal, all Q16.16.
// All handshakes are valid/ready. Register writes arrive on csr_ (index and data) and are
// always accepted; they belong in idle periods. Indexes beyond the register list are ignored.
// The six products go one at a time through a single 32x32 multiplier, interleaved with
// the saturating sums, in a fixed sequence.
// req_ready is high only while the sequencer is idle. A finished response waits in the
// output register while the next request is already being worked on; if the receiver
// still stalls when that next one is done, the sequencer holds in its last step.
// Reset (synchronous, active high) restores the register defaults, clears the
// integrator, last error and the model histories, and drops rsp_valid.
module pid_arx_closed_loop_step (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pid_arx_pkg::WORD_W-1:0]        req_step_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pid_arx_pkg::WORD_W-1:0] rsp_plant_output,
   output logic signed [pid_arx_pkg::WORD_W-1:0] rsp_control_value,
   output logic signed [pid_arx_pkg::WORD_W-1:0] rsp_model_drive,
   output logic signed [pid_arx_pkg::WORD_W-1:0] rsp_wave_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pid_arx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pid_arx_pkg::WORD_W-1:0]        csr_data
);

   pid_arx_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   pid_arx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pid_arx_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_step_index    (req_step_index),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_plant_output  (rsp_plant_output),
      .rsp_control_value (rsp_control_value),
      .rsp_model_drive   (rsp_model_drive),
      .rsp_wave_value    (rsp_wave_value)
   );

endmodule

[bench/pid_arx_closed_loop_step_test.sv]
// Self-checking testbench for the closed-loop PID and ARX model step block.
module pid_arx_closed_loop_step_test;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_PHASES = 12;
   localparam int TICKS_PER_PHASE = 105;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 30;
   localparam longint SINE_60_Q30 = 64'sd929887697;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct packed {
      pid_arx_pkg::word_type plant;
      pid_arx_pkg::word_type control;
      pid_arx_pkg::word_type drive;
      pid_arx_pkg::word_type wave;
   } loop_sample_type;

   typedef struct packed {
      logic [pid_arx_pkg::CSR_IDX_W-1:0] index;
      logic [pid_arx_pkg::WORD_W-1:0]    data;
   } reg_write_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [pid_arx_pkg::WORD_W-1:0]    req_step_index = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   pid_arx_pkg::word_type             rsp_plant_output;
   pid_arx_pkg::word_type             rsp_control_value;
   pid_arx_pkg::word_type             rsp_model_drive;
   pid_arx_pkg::word_type             rsp_wave_value;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [pid_arx_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pid_arx_pkg::WORD_W-1:0]    csr_data = '0;

   logic [pid_arx_pkg::WORD_W-1:0] pending_ticks[$];
   reg_write_type                  pending_writes[$];
   loop_sample_type                loop_due[$];

   int ticks_sent = 0;
   int ticks_checked = 0;
   int writes_sent = 0;
   int writes_done = 0;
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic hold_go = 1'b0;
   logic hold_off = 1'b0;

   // Register copy, starting from the reset defaults.
   longint gain_p = 65536;
   longint gain_i = 6554;
   longint gain_d = 3277;
   longint setpoint = 0;
   logic [pid_arx_pkg::MODE_W-1:0] mode_sel = pid_arx_pkg::WAVE_SQUARE;
   longint coef_a1 = 32768;
   longint coef_b0 = 39322;
   longint coef_b1 = 45875;

   // Loop state: integrator, previous error, model input and output history.
   longint err_total = 0;
   longint err_prev = 0;
   longint drive_prev[2] = '{0, 0};
   longint plant_prev = 0;

   pid_arx_closed_loop_step i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_step_index    (req_step_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_plant_output  (rsp_plant_output),
      .rsp_control_value (rsp_control_value),
      .rsp_model_drive   (rsp_model_drive),
      .rsp_wave_value    (rsp_wave_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic longint clamp32(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // Full product, rounded to nearest with ties upward, fraction dropped.
   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< (pid_arx_pkg::FRAC_BITS - 1))) >>> pid_arx_pkg::FRAC_BITS;
   endfunction

   function automatic longint excitation(input logic [pid_arx_pkg::WORD_W-1:0] idx,
                                         input logic [pid_arx_pkg::MODE_W-1:0] mode);
      longint one_q;
      longint sine_q;
      one_q = 64'sd1 <<< pid_arx_pkg::FRAC_BITS;
      sine_q = (SINE_60_Q30 + (64'sd1 <<< (29 - pid_arx_pkg::FRAC_BITS)))
               >>> (30 - pid_arx_pkg::FRAC_BITS);
      case (mode)
         pid_arx_pkg::WAVE_SINE: begin
            case (idx % 32'd6)
               32'd1, 32'd2: return sine_q;
               32'd4, 32'd5: return -sine_q;
               default:      return 0;
            endcase
         end
         pid_arx_pkg::WAVE_SQUARE: return (idx % 32'd3 < 32'd2) ? one_q : 0;
         default:                  return (idx >= 32'd5) ? one_q : 0;
      endcase
   endfunction

   function automatic void advance_loop(input logic [pid_arx_pkg::WORD_W-1:0] idx);
      longint wave_q;
      longint plant_q;
      longint err_q;
      longint diff_q;
      longint ctrl_q;
      longint drive_q;
      loop_sample_type due;
      wave_q = excitation(idx, mode_sel);
      plant_q = clamp32(fix_mul(coef_b0, drive_prev[0]) + fix_mul(coef_b1, drive_prev[1])
                        - fix_mul(coef_a1, plant_prev));
      err_q = clamp32(setpoint - plant_q);
      err_total = clamp32(err_total + err_q);
      diff_q = clamp32(err_q - err_prev);
      ctrl_q = clamp32(fix_mul(gain_p, err_q) + fix_mul(gain_i, err_total)
                       + fix_mul(gain_d, diff_q));
      err_prev = err_q;
      drive_q = clamp32(wave_q + ctrl_q);
      drive_prev[1] = drive_prev[0];
      drive_prev[0] = drive_q;
      plant_prev = plant_q;
      due.plant = pid_arx_pkg::word_type'(plant_q);
      due.control = pid_arx_pkg::word_type'(ctrl_q);
      due.drive = pid_arx_pkg::word_type'(drive_q);
      due.wave = pid_arx_pkg::word_type'(wave_q);
      loop_due = {loop_due, due};
   endfunction

   function automatic void apply_register(input logic [pid_arx_pkg::CSR_IDX_W-1:0] index,
                                          input logic [pid_arx_pkg::WORD_W-1:0] data);
      case (index)
         pid_arx_pkg::REG_GAIN_P:    gain_p = longint'($signed(data));
         pid_arx_pkg::REG_GAIN_I:    gain_i = longint'($signed(data));
         pid_arx_pkg::REG_GAIN_D:    gain_d = longint'($signed(data));
         pid_arx_pkg::REG_TARGET:    setpoint = longint'($signed(data));
         pid_arx_pkg::REG_WAVE_MODE: mode_sel = data[pid_arx_pkg::MODE_W-1:0];
         pid_arx_pkg::REG_FB_COEF1:  coef_a1 = longint'($signed(data));
         pid_arx_pkg::REG_FWD_COEF0: coef_b0 = longint'($signed(data));
         pid_arx_pkg::REG_FWD_COEF1: coef_b1 = longint'($signed(data));
         default:                    ;
      endcase
   endfunction

   // Mostly values within +-span, sometimes a rail or a raw word.
   function automatic logic [pid_arx_pkg::WORD_W-1:0] pick_q(input int unsigned span);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 85) return pid_arx_pkg::WORD_W'($urandom_range(2 * span)) - span;
      if (roll < 90) return 32'h7fff_ffff;
      if (roll < 95) return 32'h8000_0000;
      return $urandom();
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   task automatic send_index(input logic [pid_arx_pkg::WORD_W-1:0] idx);
      pending_ticks = {pending_ticks, idx};
      ticks_sent++;
   endtask

   task automatic wait_idle();
      while (ticks_checked != ticks_sent) @(posedge clock);
   endtask

   // Registers change only once every request has produced its response.
   task automatic write_reg(input logic [pid_arx_pkg::CSR_IDX_W-1:0] index,
                            input logic [pid_arx_pkg::WORD_W-1:0] data);
      reg_write_type w;
      wait_idle();
      w.index = index;
      w.data = data;
      pending_writes = {pending_writes, w};
      writes_sent++;
      while (writes_done != writes_sent) @(posedge clock);
   endtask

   always @(posedge clock) begin : csr_driver
      logic taken;
      reg_write_type w;
      taken = csr_valid && csr_ready;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (taken) begin
            apply_register(csr_index, csr_data);
            writes_done++;
         end
         if (!csr_valid || taken) begin
            if (pending_writes.size() != 0) begin
               w = pending_writes[0];
               pending_writes.delete(0);
               csr_valid <= 1'b1;
               csr_index <= w.index;
               csr_data <= w.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : tick_driver
      logic taken;
      taken = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (taken) begin
            advance_loop(req_step_index);
         end
         if (!req_valid || taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_step_index <= pending_ticks[0];
               pending_ticks.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      loop_sample_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (loop_due.size() == 0) begin
               report_mismatch($sformatf("response with no request outstanding, plant_output %0d",
                                         rsp_plant_output));
            end else begin
               want = loop_due[0];
               loop_due.delete(0);
               if (rsp_plant_output !== want.plant)
                  report_mismatch($sformatf("plant_output %0d, expected %0d (response %0d)",
                                            rsp_plant_output, want.plant, ticks_checked));
               if (rsp_control_value !== want.control)
                  report_mismatch($sformatf("control_value %0d, expected %0d (response %0d)",
                                            rsp_control_value, want.control, ticks_checked));
               if (rsp_model_drive !== want.drive)
                  report_mismatch($sformatf("model_drive %0d, expected %0d (response %0d)",
                                            rsp_model_drive, want.drive, ticks_checked));
               if (rsp_wave_value !== want.wave)
                  report_mismatch($sformatf("wave_value %0d, expected %0d (response %0d)",
                                            rsp_wave_value, want.wave, ticks_checked));
               ticks_checked++;
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Holds the receiver off long enough for the block to back up
   // and refuse further requests.
   initial begin : receiver_hold
      wait (hold_go);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      logic [pid_arx_pkg::WORD_W-1:0] seq_base;
      logic [pid_arx_pkg::WORD_W-1:0] mode_word;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults with the square wave, index extremes included.
      send_index(32'd0);
      send_index(32'd1);
      send_index(32'd2);
      send_index(32'd3);
      send_index(32'hffff_ffff);
      send_index(32'h8000_0000);

      // Step edge between index 4 and 5.
      write_reg(pid_arx_pkg::REG_WAVE_MODE, pid_arx_pkg::WORD_W'(pid_arx_pkg::WAVE_STEP));
      send_index(32'd4);
      send_index(32'd5);
      send_index(32'h7fff_ffff);

      // One full sine period, then an index whose remainder wraps.
      write_reg(pid_arx_pkg::REG_WAVE_MODE, pid_arx_pkg::WORD_W'(pid_arx_pkg::WAVE_SINE));
      for (int n = 0; n < 6; n++) send_index(pid_arx_pkg::WORD_W'(n));
      send_index(32'hffff_ffff);

      // The unused mode code behaves as the step.
      write_reg(pid_arx_pkg::REG_WAVE_MODE,
                {{(pid_arx_pkg::WORD_W - pid_arx_pkg::MODE_W){1'b1}}, 2'd3});
      send_index(32'd4);
      send_index(32'd5);

      // Rails on every gain, target and coefficient register to drive each sum into saturation.
      write_reg(pid_arx_pkg::REG_GAIN_P, 32'h7fff_ffff);
      write_reg(pid_arx_pkg::REG_GAIN_I, 32'h7fff_ffff);
      write_reg(pid_arx_pkg::REG_GAIN_D, 32'h8000_0000);
      write_reg(pid_arx_pkg::REG_TARGET, 32'h7fff_ffff);
      write_reg(pid_arx_pkg::REG_WAVE_MODE, pid_arx_pkg::WORD_W'(pid_arx_pkg::WAVE_SQUARE));
      write_reg(pid_arx_pkg::REG_FB_COEF1, 32'h8000_0000);
      write_reg(pid_arx_pkg::REG_FWD_COEF0, 32'h7fff_ffff);
      write_reg(pid_arx_pkg::REG_FWD_COEF1, 32'h7fff_ffff);
      send_index(32'd0);
      send_index(32'd1);
      send_index(32'd2);
      write_reg(pid_arx_pkg::REG_TARGET, 32'h8000_0000);
      write_reg(pid_arx_pkg::REG_WAVE_MODE, pid_arx_pkg::WORD_W'(pid_arx_pkg::WAVE_STEP));
      // Writes past the register list must leave everything unchanged.
      write_reg(4'd8, 32'h0000_0001);
      write_reg(4'd15, $urandom());
      send_index(32'd9);
      send_index(32'd9);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_reg(pid_arx_pkg::REG_GAIN_P, pick_q(98304));
         write_reg(pid_arx_pkg::REG_GAIN_I, pick_q(13107));
         write_reg(pid_arx_pkg::REG_GAIN_D, pick_q(32768));
         write_reg(pid_arx_pkg::REG_TARGET, pick_q(262144));
         mode_word = $urandom();
         mode_word[pid_arx_pkg::MODE_W-1:0] = pid_arx_pkg::MODE_W'($urandom_range(3));
         write_reg(pid_arx_pkg::REG_WAVE_MODE, mode_word);
         write_reg(pid_arx_pkg::REG_FB_COEF1, pick_q(58982));
         write_reg(pid_arx_pkg::REG_FWD_COEF0, pick_q(52429));
         write_reg(pid_arx_pkg::REG_FWD_COEF1, pick_q(52429));
         if ($urandom_range(3) == 0) begin
            write_reg(pid_arx_pkg::CSR_IDX_W'($urandom_range(15, 8)), $urandom());
         end

         case (phase % 4)
            0: begin
               sender_idle_pct <= 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct <= 57;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct <= 0;
               receiver_stall_pct <= 57;
            end
            default: begin
               sender_idle_pct <= 24;
               receiver_stall_pct <= 24;
            end
         endcase

         // Mostly a running time index, as a simulation loop would count,
         // with an occasional jump to an arbitrary index.
         seq_base = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            if ($urandom_range(9) < 8) begin
               send_index(seq_base + pid_arx_pkg::WORD_W'(i));
            end else begin
               send_index($urandom());
            end
         end

         if (phase == 2) begin
            hold_go = 1'b1;
         end
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && loop_due.size() == 0) begin
         $display("[pid_arx_closed_loop_step] OK");
      end else begin
         $display("[pid_arx_closed_loop_step] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("[pid_arx_closed_loop_step] ERROR");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/pid_arx_pkg.sv
hw/rtl/pid_arx_ctrl.sv
hw/rtl/pid_arx_dp.sv
hw/rtl/pid_arx_closed_loop_step.sv
bench/pid_arx_closed_loop_step_test.sv
